FILE: hw/rtl/aip_pkg.sv
// Package for the ASCII integer parser: widths, codes and the result struct.
package aip_pkg;

	localparam int MAX_CHARS  = 31;
	localparam int VALUE_BITS = 64;
	localparam int MAG_W      = VALUE_BITS - 1;
	localparam int BASE_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int END_W      = 5;
	localparam int STAT_W     = 2;
	localparam int POS_W      = $clog2(MAX_CHARS + 1);
	localparam int PROD_W     = MAG_W + BASE_W + 1;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
	localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_BAD_BASE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE    = 2'd2;

	localparam logic [0:0] REG_NUMBER_BASE = 1'b0;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_MINUS = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;

	typedef struct packed {
		logic                         valid;
		logic signed [VALUE_BITS-1:0] value;
		logic [END_W-1:0]             end_offset;
		logic [STAT_W-1:0]            status;
	} result_t;

endpackage

FILE: hw/rtl/ascii_integer_parser.sv
// Top level of the ASCII integer parser: input register, step core, result register.
// Usage:
//  Characters of a string enter on the input channel (in_valid/in_ready), one
//  request per byte; first_char marks the first byte of a new string. The
//  parser skips whitespace, takes one sign, detects the radix when
//  number_base is 0, and gives one result request (value, end_offset, status)
//  on the output channel (out_valid/out_ready) when the string stops: on NUL,
//  on a character that cannot continue the number, on overflow, or after 31
//  positions. Characters after the result and before the next first_char
//  give nothing.
//  A character is registered in the input register at acceptance, stepped
//  once the result register is empty or being read, and its result registered there.
//  Throughput: one character per cycle while the receiver does not stall; the
//  state update (one 63x6 multiply, add and overflow check) is combinational.
//  Reset clears the channel valid flags and all parse state; number_base returns to 10.
//  When the receiver stalls, the result register holds its request; the input
//  register still takes one more character and then in_ready drops.
//  number_base is read when a first_char is stepped; write it only while idle.
module ascii_integer_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [aip_pkg::ADDR_W-1:0]          paddr,
	input  logic [aip_pkg::DATA_W-1:0]          pwdata,
	output logic [aip_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [aip_pkg::CHAR_W-1:0]          character,
	input  logic                                first_char,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [aip_pkg::VALUE_BITS-1:0] value,
	output logic [aip_pkg::END_W-1:0]           end_offset,
	output logic [aip_pkg::STAT_W-1:0]          status
);
	import aip_pkg::*;

	logic [BASE_W-1:0] number_base;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              first_s1;
	logic              step;
	result_t           res;
	logic              out_valid_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic [END_W-1:0]  end_q;
	logic [STAT_W-1:0] status_q;

	aip_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.number_base (number_base)
	);

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= character;
			first_s1 <= first_char;
		end
	end

	aip_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step),
		.character   (char_s1),
		.first_char  (first_s1),
		.number_base (number_base),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			value_q  <= res.value;
			end_q    <= res.end_offset;
			status_q <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign end_offset = end_q;
	assign status     = status_q;
endmodule

FILE: hw/rtl/aip_apb_regs.sv
// APB register file holding the number_base configuration register.
module aip_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [aip_pkg::ADDR_W-1:0]   paddr,
	input  logic [aip_pkg::DATA_W-1:0]   pwdata,
	output logic [aip_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output logic [aip_pkg::BASE_W-1:0]   number_base
);
	import aip_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic              sel_base;

	assign pready   = 1'b1;
	assign sel_base = (paddr[2] == REG_NUMBER_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (psel && penable && pwrite && pready && sel_base) begin
			base_q <= pwdata[BASE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_base) begin
			prdata = DATA_W'(base_q);
		end
	end

	assign number_base = base_q;
endmodule

FILE: hw/rtl/aip_core.sv
// Parse state registers and the per-character step logic.
module aip_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [aip_pkg::CHAR_W-1:0]   character,
	input  logic                         first_char,
	input  logic [aip_pkg::BASE_W-1:0]   number_base,
	output aip_pkg::result_t             result
);
	import aip_pkg::*;

	logic [MAG_W-1:0]  mag_q;
	logic [BASE_W-1:0] wb_q;
	logic              ds_q;
	logic [1:0]        sg_q;
	logic              zp_q;
	logic [POS_W-1:0]  pos_q;
	logic              fin_q;

	logic [MAG_W-1:0]  mag;
	logic [BASE_W-1:0] wb;
	logic              ds;
	logic [1:0]        sg;
	logic              zp;
	logic [POS_W-1:0]  pos;
	logic              fin;
	logic              adv;
	logic              handled;
	logic              dig_ok;
	logic [BASE_W-1:0] dig;
	logic              is_ws;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;
	logic signed [VALUE_BITS-1:0] max_val;

	assign max_val = {1'b0, {MAG_W{1'b1}}};
	assign is_ws   = (character == CH_SPACE) ||
		(character >= CH_TAB && character <= CH_CR);

	always_comb begin
		mag     = mag_q;
		wb      = wb_q;
		ds      = ds_q;
		sg      = sg_q;
		zp      = zp_q;
		pos     = pos_q;
		fin     = fin_q;
		adv     = 1'b0;
		handled = 1'b0;
		dig_ok  = 1'b0;
		dig     = '0;
		prod    = '0;
		sum     = '0;
		result  = '0;

		if (first_char) begin
			wb  = number_base;
			mag = '0;
			ds  = 1'b0;
			sg  = SIGN_NONE;
			zp  = 1'b0;
			pos = '0;
			fin = 1'b0;
			if (wb == BASE_W'(1) || wb > BASE_MAX) begin
				result.valid  = 1'b1;
				result.status = STATUS_BAD_BASE;
				fin           = 1'b1;
			end
		end

		if (!fin) begin
			if (zp) begin
				zp = 1'b0;
				ds = 1'b1;
				if (character == CH_LOW_X || character == CH_UP_X) begin
					wb      = BASE_W'(16);
					adv     = 1'b1;
					handled = 1'b1;
				end else if (wb == '0) begin
					wb = BASE_W'(8);
				end
			end

			if (!handled) begin
				if (character == CH_NUL) begin
					result.valid      = 1'b1;
					result.end_offset = END_W'(pos);
					result.status     = STATUS_OK;
					fin               = 1'b1;
				end else if ((wb == '0 || wb == BASE_W'(16)) && !ds &&
					character == CH_ZERO &&
					(POS_W + 1)'(pos) + 1'b1 < (POS_W + 1)'(MAX_CHARS)) begin
					zp  = 1'b1;
					adv = 1'b1;
				end else if (wb == '0 && !ds && character == CH_ZERO) begin
					wb  = BASE_W'(8);
					ds  = 1'b1;
					adv = 1'b1;
				end else if (!ds && sg == SIGN_NONE && is_ws) begin
					adv = 1'b1;
				end else if (!ds && sg == SIGN_NONE &&
					(character == CH_MINUS || character == CH_PLUS)) begin
					sg  = (character == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
					adv = 1'b1;
				end else begin
					if (wb > BASE_W'(10) && character >= CH_LOW_A &&
						(character - CH_LOW_A) < CHAR_W'(wb - BASE_W'(10))) begin
						dig_ok = 1'b1;
						dig    = BASE_W'(character - CH_LOW_A) + BASE_W'(10);
					end else if (wb > BASE_W'(10) && character >= CH_UP_A &&
						(character - CH_UP_A) < CHAR_W'(wb - BASE_W'(10))) begin
						dig_ok = 1'b1;
						dig    = BASE_W'(character - CH_UP_A) + BASE_W'(10);
					end else if (character >= CH_ZERO && character <= CH_NINE &&
						(character - CH_ZERO) <
						CHAR_W'((wb == '0) ? BASE_W'(10) : wb)) begin
						dig_ok = 1'b1;
						dig    = BASE_W'(character - CH_ZERO);
						if (wb == '0) begin
							wb = BASE_W'(10);
						end
					end

					if (!dig_ok) begin
						result.valid      = 1'b1;
						result.end_offset = END_W'(pos);
						result.status     = STATUS_OK;
						fin               = 1'b1;
					end else begin
						ds = 1'b1;
						if (wb < BASE_W'(2)) begin
							wb = BASE_W'(10);
						end
						prod = {{(BASE_W + 1){1'b0}}, mag} * {{MAG_W{1'b0}}, wb};
						sum  = prod + PROD_W'(dig);
						if (|sum[PROD_W-1:MAG_W]) begin
							result.valid      = 1'b1;
							result.value      = (sg == SIGN_MINUS) ? ~max_val : max_val;
							result.end_offset = END_W'(pos + 1'b1);
							result.status     = STATUS_RANGE;
							fin               = 1'b1;
						end else begin
							mag = sum[MAG_W-1:0];
							adv = 1'b1;
						end
					end
				end
			end

			if (adv) begin
				pos = pos + 1'b1;
				if (pos >= POS_W'(MAX_CHARS)) begin
					result.valid      = 1'b1;
					result.end_offset = END_W'(pos);
					result.status     = STATUS_OK;
					fin               = 1'b1;
				end
			end

			// value uses the magnitude as updated by this step
			if (result.valid && result.status == STATUS_OK) begin
				result.value = (sg == SIGN_MINUS) ?
					(VALUE_BITS'(0) - {1'b0, mag}) : {1'b0, mag};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			wb_q  <= '0;
			ds_q  <= 1'b0;
			sg_q  <= SIGN_NONE;
			zp_q  <= 1'b0;
			pos_q <= '0;
			fin_q <= 1'b1;
		end else if (step_en) begin
			mag_q <= mag;
			wb_q  <= wb;
			ds_q  <= ds;
			sg_q  <= sg;
			zp_q  <= zp;
			pos_q <= pos;
			fin_q <= fin;
		end
	end
endmodule
